// ===== design/sstq_pkg.sv =====
// Package for the sorted sleep-timer queue: sizes, entry and result types,
// result kinds, controller states and the circular pointer helper.
// No dependencies.
`default_nettype none

package sstq_pkg;

   localparam int QUEUE_DEPTH      = 16;
   localparam int ID_BITS          = 8;
   localparam int UNITS_PER_SECOND = 1000;
   localparam int TICK_RATE_HZ     = 10000;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_BITS  = 64;
   localparam int DELAY_BITS = 32;
   localparam int PORT_ID_BITS = 8;
   localparam int PRESCALE_BITS = 16;

   localparam logic [PRESCALE_BITS-1:0] TICKS_PER_UNIT_RESET =
      PRESCALE_BITS'(TICK_RATE_HZ / UNITS_PER_SECOND);

   typedef enum logic [1:0] {
      KIND_WOKEN    = 2'd0,
      KIND_ACCEPTED = 2'd1,
      KIND_REJECTED = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_READ,
      ST_INS_CHECK,
      ST_RESPOND,
      ST_EXP_READ,
      ST_EXP_CHECK
   } state_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] wake;
      logic [ID_BITS-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [PTR_BITS-1:0]  wr_addr;
      entry_type            wr_data;
      logic                 rd_en;
      logic [PTR_BITS-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      kind_type             kind;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] wake;
      logic                 last;
   } result_type;

   function automatic logic [PTR_BITS-1:0] ptr_add(input logic [PTR_BITS-1:0] base,
                                                   input logic [COUNT_BITS-1:0] off);
      logic [COUNT_BITS:0] sum;
      sum = {{(COUNT_BITS + 1 - PTR_BITS){1'b0}}, base} + {1'b0, off};
      if (sum >= (COUNT_BITS + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (COUNT_BITS + 1)'(QUEUE_DEPTH);
      end
      return sum[PTR_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/sstq_table.sv =====
// Entry store of the sorted sleep-timer queue: one write port, one read port,
// registered read data held between reads. Depends on sstq_pkg.
`default_nettype none

module sstq_table
   import sstq_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output      entry_type   rd_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sstq_timebase.sv =====
// Time base of the sorted sleep-timer queue: ticks_per_unit register,
// prescaler and the 64-bit unit counter. Depends on sstq_pkg.
`default_nettype none

module sstq_timebase
   import sstq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [PRESCALE_BITS-1:0] csr_write_data,
   input  wire logic                     tick_advance,
   output      logic [TIME_BITS-1:0]     now_units
);

   logic [PRESCALE_BITS-1:0] ticks_per_unit_ff;
   logic [PRESCALE_BITS-1:0] prescale_ff;
   logic [PRESCALE_BITS-1:0] prescale_in;
   logic [TIME_BITS-1:0]     now_ff;
   logic [TIME_BITS-1:0]     now_in;
   logic [PRESCALE_BITS:0]   prescale_next;

   always_comb begin
      prescale_next = {1'b0, prescale_ff} + 1'b1;
      prescale_in   = prescale_ff;
      now_in        = now_ff;
      if (tick_advance) begin
         if (prescale_next >= {1'b0, ticks_per_unit_ff}) begin
            prescale_in = '0;
            now_in      = now_ff + 1'b1;
         end else begin
            prescale_in = prescale_next[PRESCALE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_unit_ff <= TICKS_PER_UNIT_RESET;
         prescale_ff       <= '0;
         now_ff            <= '0;
      end else begin
         if (csr_write_enable) begin
            ticks_per_unit_ff <= csr_write_data;
         end
         prescale_ff <= prescale_in;
         now_ff      <= now_in;
      end
   end

   assign now_units = now_ff;

endmodule

`default_nettype wire

// ===== design/sstq_ctrl.sv =====
// Controller of the sorted sleep-timer queue: sorted insert walk and expiry
// sweep over a circular table. Depends on sstq_pkg.
`default_nettype none

module sstq_ctrl
   import sstq_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic                    req_opcode,
   input  wire logic [PORT_ID_BITS-1:0] req_task_id,
   input  wire logic [DELAY_BITS-1:0]   req_delay_units,
   input  wire logic [TIME_BITS-1:0]    now_units,
   output      logic                    tick_advance,
   output      mem_req_type             mem_req,
   input  wire entry_type               rd_data,
   input  wire logic                    out_free,
   output      logic                    push,
   output      result_type              result
);

   state_type             state_ff, state_in;
   logic [PTR_BITS-1:0]   head_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] pos_ff;
   logic [TIME_BITS-1:0]  when_ff;
   logic [ID_BITS-1:0]    id_ff;
   kind_type              kind_ff;
   entry_type             pend_ff;
   logic                  have_pend_ff;

   logic                  req_accept;
   logic                  full;
   logic                  due;
   logic                  later;
   logic [TIME_BITS-1:0]  when_sum;
   logic [PTR_BITS-1:0]   ins_src;
   logic [PTR_BITS-1:0]   ins_dst;

   assign req_accept = req_valid && !req_stall;
   assign full       = (count_ff == COUNT_BITS'(QUEUE_DEPTH));
   assign due        = (rd_data.wake <= now_units);
   assign later      = (rd_data.wake > when_ff);
   assign when_sum   = now_units + {{(TIME_BITS - DELAY_BITS){1'b0}}, req_delay_units};
   assign ins_src    = ptr_add(head_ff, COUNT_BITS'(pos_ff - 1'b1));
   assign ins_dst    = ptr_add(head_ff, pos_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_opcode) begin
                  state_in = ST_EXP_READ;
               end else if (full) begin
                  state_in = ST_RESPOND;
               end else begin
                  state_in = ST_INS_READ;
               end
            end
         end
         ST_INS_READ: begin
            state_in = (pos_ff == '0) ? ST_RESPOND : ST_INS_CHECK;
         end
         ST_INS_CHECK: begin
            state_in = later ? ST_INS_READ : ST_RESPOND;
         end
         ST_RESPOND: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXP_READ: begin
            if (count_ff != '0) begin
               state_in = ST_EXP_CHECK;
            end else if (!have_pend_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXP_CHECK: begin
            if (due) begin
               if (!have_pend_ff || out_free) begin
                  state_in = ST_EXP_READ;
               end
            end else if (!have_pend_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      tick_advance    = 1'b0;
      mem_req         = '0;
      push            = 1'b0;
      result.kind     = KIND_WOKEN;
      result.id       = pend_ff.id;
      result.wake     = pend_ff.wake;
      result.last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            tick_advance = req_accept && !req_opcode;
         end
         ST_INS_READ: begin
            if (pos_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = ins_dst;
               mem_req.wr_data = entry_type'{wake: when_ff, id: id_ff};
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = ins_src;
            end
         end
         ST_INS_CHECK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ins_dst;
            mem_req.wr_data = later ? rd_data : entry_type'{wake: when_ff, id: id_ff};
         end
         ST_RESPOND: begin
            push        = out_free;
            result.kind = kind_ff;
            result.id   = id_ff;
            result.wake = when_ff;
            result.last = 1'b1;
         end
         ST_EXP_READ: begin
            if (count_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = head_ff;
            end else begin
               push        = have_pend_ff && out_free;
               result.last = 1'b1;
            end
         end
         ST_EXP_CHECK: begin
            push        = have_pend_ff && out_free;
            result.last = !due;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         have_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && req_accept && !req_opcode) begin
            have_pend_ff <= 1'b0;
         end
         if ((state_ff == ST_INS_READ && pos_ff == '0) ||
             (state_ff == ST_INS_CHECK && !later)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (state_ff == ST_EXP_CHECK && due && (!have_pend_ff || out_free)) begin
            have_pend_ff <= 1'b1;
            head_ff      <= ptr_add(head_ff, COUNT_BITS'(1));
            count_ff     <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept && req_opcode) begin
         when_ff <= when_sum;
         id_ff   <= req_task_id[ID_BITS-1:0];
         pos_ff  <= count_ff;
         kind_ff <= full ? KIND_REJECTED : KIND_ACCEPTED;
      end
      if (state_ff == ST_INS_CHECK && later) begin
         pos_ff <= COUNT_BITS'(pos_ff - 1'b1);
      end
      if (state_ff == ST_EXP_CHECK && due && (!have_pend_ff || out_free)) begin
         pend_ff <= rd_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/sorted_sleep_timer_queue.sv =====
// Top level of the sorted sleep-timer queue: time base, entry store,
// controller and the response register. Depends on sstq_pkg and all sstq_ modules.
//
// Usage: a request transaction is either a tick (opcode 0) or a sleep request
// (opcode 1, task_id, delay_units). One request is handled at a time; req_stall
// stays high until its last response transaction has been placed in the
// response register.
// Sleep: the wake time is now plus delay; the entry is placed in wake-time
// order after equal times by walking the table from the tail, each later
// entry read and moved up one place, before the single accepted response
// (last set). A full table gives a rejection.
// Tick: the prescaler advances and the time counter steps when it wraps,
// then due entries are taken from the head in order; a tick with nothing
// due gives no response. The final woken response carries last. Each entry
// takes a read state and a check state, as the memory read is registered.
// Responses leave through one output register; while rsp_stall is high the
// transaction holds and the controller waits for it before the next.
// Reset (synchronous, active high) empties the table, clears time and
// prescaler and sets ticks_per_unit to 10. csr writes are taken every cycle.
`default_nettype none

module sorted_sleep_timer_queue
   import sstq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write_enable,
   input  wire logic [PRESCALE_BITS-1:0] csr_write_data,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [PORT_ID_BITS-1:0]  req_task_id,
   input  wire logic [DELAY_BITS-1:0]    req_delay_units,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [1:0]               rsp_kind,
   output      logic [PORT_ID_BITS-1:0]  rsp_woken_id,
   output      logic [TIME_BITS-1:0]     rsp_wake_time,
   output      logic                     rsp_last
);

   logic                 tick_advance;
   logic [TIME_BITS-1:0] now_units;
   mem_req_type          mem_req;
   entry_type            rd_data;
   logic                 out_free;
   logic                 push;
   result_type           result;
   logic                 rsp_valid_ff;
   result_type           rsp_ff;

   sstq_timebase u_timebase (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .tick_advance     (tick_advance),
      .now_units        (now_units)
   );

   sstq_table u_table (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   sstq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_task_id     (req_task_id),
      .req_delay_units (req_delay_units),
      .now_units       (now_units),
      .tick_advance    (tick_advance),
      .mem_req         (mem_req),
      .rd_data         (rd_data),
      .out_free        (out_free),
      .push            (push),
      .result          (result)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_ff.kind;
   assign rsp_woken_id  = PORT_ID_BITS'(rsp_ff.id);
   assign rsp_wake_time = rsp_ff.wake;
   assign rsp_last      = rsp_ff.last;

endmodule

`default_nettype wire

// ===== tb/sv/sorted_sleep_timer_queue_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sorted_sleep_timer_queue: directed and random request transactions,
// each response checked against an in-bench prediction of the sorted timer table.
// Depends on sstq_pkg and the design files of the block.

module sorted_sleep_timer_queue_tb;
   import sstq_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_WAKE      = 16;
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_SLEEP    = 1'b1;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [PRESCALE_BITS-1:0] csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OP_TICK;
   logic [PORT_ID_BITS-1:0]  req_task_id = '0;
   logic [DELAY_BITS-1:0]    req_delay_units = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_kind;
   logic [PORT_ID_BITS-1:0]  rsp_woken_id;
   logic [TIME_BITS-1:0]     rsp_wake_time;
   logic                     rsp_last;

   // predicted block state
   logic [PRESCALE_BITS-1:0] units_divisor = TICKS_PER_UNIT_RESET;
   logic [PRESCALE_BITS-1:0] tick_prescale = '0;
   logic [TIME_BITS-1:0]     now_time = '0;
   logic [TIME_BITS-1:0]     sleeper_wake [QUEUE_DEPTH];
   logic [ID_BITS-1:0]       sleeper_id [QUEUE_DEPTH];
   int                       sleeper_count = 0;
   result_type               pending_responses [$];

   int   error_count = 0;
   int   hold_off_cycles = 0;
   bit   idling_on = 1'b1;
   bit   req_held = 1'b0;

   sorted_sleep_timer_queue u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_task_id      (req_task_id),
      .req_delay_units  (req_delay_units),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_woken_id     (rsp_woken_id),
      .rsp_wake_time    (rsp_wake_time),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_gap();
      int pick;
      if (!idling_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void predict_responses(logic op, logic [PORT_ID_BITS-1:0] task_id,
                                             logic [DELAY_BITS-1:0] delay);
      logic [TIME_BITS-1:0] due;
      int                   pos;
      int                   woken;
      result_type           r;
      if (op == OP_SLEEP) begin
         due    = now_time + TIME_BITS'(delay);
         r.id   = task_id[ID_BITS-1:0];
         r.wake = due;
         r.last = 1'b1;
         if (sleeper_count >= QUEUE_DEPTH) begin
            r.kind = KIND_REJECTED;
         end else begin
            pos = 0;
            while (pos < sleeper_count && sleeper_wake[pos] <= due) pos++;
            for (int i = sleeper_count; i > pos; i--) begin
               sleeper_wake[i] = sleeper_wake[i-1];
               sleeper_id[i]   = sleeper_id[i-1];
            end
            sleeper_wake[pos] = due;
            sleeper_id[pos]   = task_id[ID_BITS-1:0];
            sleeper_count++;
            r.kind = KIND_ACCEPTED;
         end
         pending_responses.push_back(r);
      end else begin
         if (int'(tick_prescale) + 1 >= int'(units_divisor)) begin
            tick_prescale = '0;
            now_time++;
         end else begin
            tick_prescale++;
         end
         woken = 0;
         while (woken < MAX_WAKE && woken < sleeper_count && sleeper_wake[woken] <= now_time)
            woken++;
         for (int i = 0; i < woken; i++) begin
            r.kind = KIND_WOKEN;
            r.id   = sleeper_id[i];
            r.wake = sleeper_wake[i];
            r.last = (i == woken - 1);
            pending_responses.push_back(r);
         end
         for (int i = woken; i < sleeper_count; i++) begin
            sleeper_wake[i-woken] = sleeper_wake[i];
            sleeper_id[i-woken]   = sleeper_id[i];
         end
         sleeper_count -= woken;
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
      $display("%0t: response mismatch on %s: got %0h, expected %0h", $time, what, got, wanted);
      error_count++;
   endtask

   task automatic send_request(logic op, logic [PORT_ID_BITS-1:0] task_id,
                               logic [DELAY_BITS-1:0] delay);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         if (req_held) req_valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_task_id     <= task_id;
      req_delay_units <= delay;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_held = 1'b1;
      predict_responses(op, task_id, delay);
   endtask

   task automatic wait_for_idle();
      if (req_held) req_valid <= 1'b0;
      req_held = 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ticks_per_unit(logic [PRESCALE_BITS-1:0] value);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      units_divisor = value;
      @(posedge clock);
   endtask

   task automatic test_sleep_zero_delay();
      send_request(OP_SLEEP, 8'h00, 32'd0);
      send_request(OP_TICK, PORT_ID_BITS'($urandom), DELAY_BITS'($urandom));
      send_request(OP_TICK, PORT_ID_BITS'($urandom), DELAY_BITS'($urandom));
   endtask

   task automatic test_full_table();
      write_ticks_per_unit(16'd1);
      while (sleeper_count < QUEUE_DEPTH)
         send_request(OP_SLEEP, PORT_ID_BITS'($urandom), DELAY_BITS'($urandom_range(0, 1)));
      send_request(OP_SLEEP, 8'hFF, 32'hFFFF_FFFF);
      send_request(OP_TICK, '0, '0);
   endtask

   task automatic test_lowered_prescaler();
      write_ticks_per_unit(16'd10);
      repeat (3) send_request(OP_TICK, '0, '0);
      write_ticks_per_unit(16'd2);
      send_request(OP_SLEEP, 8'h5A, 32'd1);
      send_request(OP_TICK, '0, '0);
   endtask

   task automatic test_zero_divisor();
      write_ticks_per_unit(16'd0);
      send_request(OP_SLEEP, 8'hA5, 32'd2);
      send_request(OP_TICK, '0, '0);
      send_request(OP_TICK, '0, '0);
   endtask

   task automatic test_backpressure();
      write_ticks_per_unit(16'd1);
      hold_off_cycles = 300;
      repeat (6) begin
         send_request(OP_SLEEP, PORT_ID_BITS'($urandom), 32'd0);
         send_request(OP_TICK, '0, '0);
      end
   endtask

   task automatic test_random_traffic();
      logic [PRESCALE_BITS-1:0] divisors [6] = '{16'd1, 16'd3, 16'd65535, 16'd2, 16'd0, 16'd10};
      logic [DELAY_BITS-1:0]    delay;
      foreach (divisors[p]) begin
         write_ticks_per_unit(divisors[p]);
         idling_on = (p % 2 == 0);
         repeat (35) begin
            if ($urandom_range(0, 1) == 1) begin
               if ($urandom_range(0, 39) == 0) delay = DELAY_BITS'($urandom);
               else delay = DELAY_BITS'($urandom_range(0, 6));
               send_request(OP_SLEEP, PORT_ID_BITS'($urandom), delay);
            end else begin
               send_request(OP_TICK, PORT_ID_BITS'($urandom), DELAY_BITS'($urandom));
            end
         end
      end
      idling_on = 1'b1;
   endtask

   initial begin : response_stall
      int run;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            run = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
         end else begin
            rsp_stall <= idling_on && ($urandom_range(0, 2) == 0);
            repeat (idle_gap() + 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : response_check
      result_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_wake_time, '0);
         end else begin
            wanted = pending_responses.pop_front();
            if (rsp_kind !== wanted.kind)
               report_mismatch("kind", 64'(rsp_kind), 64'(wanted.kind));
            if (rsp_woken_id !== wanted.id)
               report_mismatch("woken_id", 64'(rsp_woken_id), 64'(wanted.id));
            if (rsp_wake_time !== wanted.wake)
               report_mismatch("wake_time", rsp_wake_time, wanted.wake);
            if (rsp_last !== wanted.last)
               report_mismatch("last", 64'(rsp_last), 64'(wanted.last));
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : test_sequence
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sleep_zero_delay();
      test_full_table();
      test_lowered_prescaler();
      test_zero_divisor();
      test_backpressure();
      test_random_traffic();
      wait_for_idle();
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
